FILE: rtl/abbt_pkg.sv
// Shared types and constants of the alpha bounding box trim block.
`default_nettype none

package abbt_pkg;

  // Field widths of the register file and of one result beat
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned WIN_W   = 14;
  localparam int unsigned ALPHA_W = 8;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned EXT_W   = 13;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned CLIP_W  = 16;

  // Register indexes of the configuration port
  typedef enum logic [IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_WINDOW_X      = 3'd2,
    CFG_WINDOW_Y      = 3'd3,
    CFG_WINDOW_WIDTH  = 3'd4,
    CFG_WINDOW_HEIGHT = 3'd5
  } cfg_reg_e;

  // Register values after reset
  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH   = 13'd4096;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT  = 13'd4096;
  localparam logic [WIN_W-1:0] RST_WINDOW_X      = 14'd0;
  localparam logic [WIN_W-1:0] RST_WINDOW_Y      = 14'd0;
  localparam logic [WIN_W-1:0] RST_WINDOW_WIDTH  = 14'd4096;
  localparam logic [WIN_W-1:0] RST_WINDOW_HEIGHT = 14'd4096;

  // One axis of the clipped window: start and one past the end
  typedef struct packed {
    logic             ok;
    logic [DIM_W-1:0] start;
    logic [DIM_W-1:0] stop;
  } clip_t;

endpackage

`default_nettype wire

FILE: rtl/abbt_if.sv
// Handshake channels of the alpha bounding box trim block.
`default_nettype none

// Pixel channel: one alpha byte per beat
interface abbt_pix_if;
  logic                          valid;
  logic                          ready;
  logic [abbt_pkg::ALPHA_W-1:0]  alpha;

  modport source (output valid, output alpha, input ready);
  modport sink (input valid, input alpha, output ready);
endinterface

// Result channel: one bounding box per frame
interface abbt_res_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [abbt_pkg::POS_W-1:0]  box_left;
  logic [abbt_pkg::POS_W-1:0]  box_top;
  logic [abbt_pkg::EXT_W-1:0]  box_width;
  logic [abbt_pkg::EXT_W-1:0]  box_height;

  modport source (output valid, output found, output box_left, output box_top,
                  output box_width, output box_height, input ready);
  modport sink (input valid, input found, input box_left, input box_top,
                input box_width, input box_height, output ready);
endinterface

// Configuration write channel
interface abbt_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [abbt_pkg::IDX_W-1:0]  index;
  logic [abbt_pkg::WIN_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/alpha_bounding_box_trim.sv
// Top level: tracks the opaque bounding box of each frame inside a clipped window.
//
//   channel  dir  beat contents
//   -------  ---  -----------------------------------------------------
//   pix_i    in   alpha byte of the next pixel, raster order
//   res_o    out  found, box_left, box_top, box_width, box_height
//   cfg_i    in   register index and write data, always ready
//
// One pixel beat per clock sustained while no result is stalled. A pixel
// is scored from the input register against the window and box state in
// the cycle after its beat, and on the frame's last pixel the box lands in
// the result register at the end of that cycle. Reset clears the counters,
// the box and the handshake state and loads the register defaults. A
// stalled result holds the pipe; the input stage still takes one more
// pixel behind it.
`default_nettype none

module alpha_bounding_box_trim #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  abbt_pix_if.sink        pix_i,
  abbt_cfg_if.sink        cfg_i,
  abbt_res_if.source      res_o
);

  localparam int unsigned DW  = abbt_pkg::DIM_W;
  localparam int unsigned WW  = abbt_pkg::WIN_W;
  localparam int unsigned CNW = ($clog2(MAX_DIM) > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned PW  = (CNW + 1 > WW) ? CNW + 1 : WW;
  localparam int unsigned LW  = (CNW > abbt_pkg::POS_W) ? CNW : abbt_pkg::POS_W;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [DW-1:0] img_w_q, img_w_d, img_h_q, img_h_d;
  logic [WW-1:0] win_x_q, win_x_d, win_y_q, win_y_d;
  logic [WW-1:0] win_w_q, win_w_d, win_h_q, win_h_d;
  logic [DW-1:0] size_w_q, size_w_d, size_h_q, size_h_d;
  abbt_pkg::clip_t clip_x_q, clip_x_d, clip_y_q, clip_y_d;

  assign cfg_i.ready = 1'b1;

  // Decode a write beat
  always_comb begin
    img_w_d = img_w_q;
    img_h_d = img_h_q;
    win_x_d = win_x_q;
    win_y_d = win_y_q;
    win_w_d = win_w_q;
    win_h_d = win_h_q;
    if (cfg_i.valid) begin
      unique case (abbt_pkg::cfg_reg_e'(cfg_i.index))
        abbt_pkg::CFG_IMAGE_WIDTH:   img_w_d = cfg_i.data[DW-1:0];
        abbt_pkg::CFG_IMAGE_HEIGHT:  img_h_d = cfg_i.data[DW-1:0];
        abbt_pkg::CFG_WINDOW_X:      win_x_d = cfg_i.data;
        abbt_pkg::CFG_WINDOW_Y:      win_y_d = cfg_i.data;
        abbt_pkg::CFG_WINDOW_WIDTH:  win_w_d = cfg_i.data;
        abbt_pkg::CFG_WINDOW_HEIGHT: win_h_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  // Saturate the image size to 1..MAX_DIM
  always_comb begin
    if (img_w_d == '0) begin
      size_w_d = DW'(1);
    end else if (32'(img_w_d) > MAX_DIM) begin
      size_w_d = DW'(MAX_DIM);
    end else begin
      size_w_d = img_w_d;
    end
    if (img_h_d == '0) begin
      size_h_d = DW'(1);
    end else if (32'(img_h_d) > MAX_DIM) begin
      size_h_d = DW'(MAX_DIM);
    end else begin
      size_h_d = img_h_d;
    end
  end

  // Clip the window from the next register values so it tracks every write
  abbt_clip_axis u_clip_x (
    .size_i (size_w_d),
    .org_i  (win_x_d),
    .len_i  (win_w_d),
    .clip_o (clip_x_d)
  );

  abbt_clip_axis u_clip_y (
    .size_i (size_h_d),
    .org_i  (win_y_d),
    .len_i  (win_h_d),
    .clip_o (clip_y_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q  <= abbt_pkg::RST_IMAGE_WIDTH;
      img_h_q  <= abbt_pkg::RST_IMAGE_HEIGHT;
      win_x_q  <= abbt_pkg::RST_WINDOW_X;
      win_y_q  <= abbt_pkg::RST_WINDOW_Y;
      win_w_q  <= abbt_pkg::RST_WINDOW_WIDTH;
      win_h_q  <= abbt_pkg::RST_WINDOW_HEIGHT;
      size_w_q <= '0;
      size_h_q <= '0;
      clip_x_q <= '0;
      clip_y_q <= '0;
    end else begin
      img_w_q  <= img_w_d;
      img_h_q  <= img_h_d;
      win_x_q  <= win_x_d;
      win_y_q  <= win_y_d;
      win_w_q  <= win_w_d;
      win_h_q  <= win_h_d;
      size_w_q <= size_w_d;
      size_h_q <= size_h_d;
      clip_x_q <= clip_x_d;
      clip_y_q <= clip_y_d;
    end
  end

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic                         in_vld_q;
  logic [abbt_pkg::ALPHA_W-1:0] in_alpha_q;
  logic                         out_free;
  logic                         fire;

  assign out_free    = !res_o.valid || res_o.ready;
  assign fire        = in_vld_q && out_free;
  assign pix_i.ready = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (pix_i.ready) begin
      in_vld_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_i.valid && pix_i.ready) begin
      in_alpha_q <= pix_i.alpha;
    end
  end

  // ---------------------------------------------------------------------
  // Position counters and box state
  // ---------------------------------------------------------------------
  logic [CNW-1:0] col_q, col_d, row_q, row_d;
  logic [CNW-1:0] fcol_q, fcol_d, lcol_q, lcol_d;
  logic [CNW-1:0] frow_q, frow_d, lrow_q, lrow_d;
  logic           seen_q, seen_d;

  logic [PW-1:0]  col_x, row_x, cx_x, cy_x, ex_x, ey_x;
  logic [PW-1:0]  col_inc, row_inc, w_x, h_x;
  logic [PW-1:0]  rc_x, rr_x;
  logic [CNW-1:0] rc, rr;
  logic           hit, row_end, frame_end;

  assign col_x   = PW'(col_q);
  assign row_x   = PW'(row_q);
  assign cx_x    = PW'(clip_x_q.start);
  assign cy_x    = PW'(clip_y_q.start);
  assign ex_x    = PW'(clip_x_q.stop);
  assign ey_x    = PW'(clip_y_q.stop);
  assign w_x     = PW'(size_w_q);
  assign h_x     = PW'(size_h_q);
  assign col_inc = col_x + PW'(1);
  assign row_inc = row_x + PW'(1);

  // Score the pixel against the clipped window
  assign hit = clip_x_q.ok && clip_y_q.ok && (in_alpha_q != '0)
            && (col_x >= cx_x) && (col_x < ex_x)
            && (row_x >= cy_x) && (row_x < ey_x);
  assign rc_x = col_x - cx_x;
  assign rr_x = row_x - cy_x;
  assign rc   = rc_x[CNW-1:0];
  assign rr   = rr_x[CNW-1:0];

  assign row_end   = !(col_inc < w_x);
  assign frame_end = row_end && !(row_inc < h_x);

  // Widen the box on a hit
  always_comb begin
    fcol_d = fcol_q;
    lcol_d = lcol_q;
    frow_d = frow_q;
    lrow_d = lrow_q;
    seen_d = seen_q;
    if (hit) begin
      if (!seen_q) begin
        fcol_d = rc;
        lcol_d = rc;
        frow_d = rr;
        lrow_d = rr;
        seen_d = 1'b1;
      end else begin
        if (rc < fcol_q) fcol_d = rc;
        if (rc > lcol_q) lcol_d = rc;
        if (rr < frow_q) frow_d = rr;
        if (rr > lrow_q) lrow_d = rr;
      end
    end
  end

  // Advance the raster position
  always_comb begin
    if (!row_end) begin
      col_d = col_inc[CNW-1:0];
      row_d = row_q;
    end else if (!frame_end) begin
      col_d = '0;
      row_d = row_inc[CNW-1:0];
    end else begin
      col_d = '0;
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      fcol_q <= '0;
      lcol_q <= '0;
      frow_q <= '0;
      lrow_q <= '0;
      seen_q <= 1'b0;
    end else if (fire) begin
      col_q <= col_d;
      row_q <= row_d;
      if (frame_end) begin
        fcol_q <= '0;
        lcol_q <= '0;
        frow_q <= '0;
        lrow_q <= '0;
        seen_q <= 1'b0;
      end else begin
        fcol_q <= fcol_d;
        lcol_q <= lcol_d;
        frow_q <= frow_d;
        lrow_q <= lrow_d;
        seen_q <= seen_d;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic [PW-1:0]                box_w_x, box_h_x;
  logic [LW-1:0]                left_x, top_x;
  logic                         res_vld_q;
  logic                         found_q;
  logic [abbt_pkg::POS_W-1:0]   left_q, top_q;
  logic [abbt_pkg::EXT_W-1:0]   bw_q, bh_q;

  assign box_w_x = PW'(lcol_d) - PW'(fcol_d) + PW'(1);
  assign box_h_x = PW'(lrow_d) - PW'(frow_d) + PW'(1);
  assign left_x  = LW'(fcol_d);
  assign top_x   = LW'(frow_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (fire && frame_end) begin
      res_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  // Load the box on the frame's last pixel, zero fields when nothing was seen
  always_ff @(posedge clk_i) begin
    if (fire && frame_end) begin
      found_q <= seen_d;
      if (seen_d) begin
        left_q <= left_x[abbt_pkg::POS_W-1:0];
        top_q  <= top_x[abbt_pkg::POS_W-1:0];
        bw_q   <= box_w_x[abbt_pkg::EXT_W-1:0];
        bh_q   <= box_h_x[abbt_pkg::EXT_W-1:0];
      end else begin
        left_q <= '0;
        top_q  <= '0;
        bw_q   <= '0;
        bh_q   <= '0;
      end
    end
  end

  assign res_o.valid      = res_vld_q;
  assign res_o.found      = found_q;
  assign res_o.box_left   = left_q;
  assign res_o.box_top    = top_q;
  assign res_o.box_width  = bw_q;
  assign res_o.box_height = bh_q;

endmodule

`default_nettype wire

FILE: rtl/abbt_clip_axis.sv
// Clips one axis of the requested window against the image size.
`default_nettype none

module abbt_clip_axis (
  input  wire logic [abbt_pkg::DIM_W-1:0] size_i,
  input  wire logic [abbt_pkg::WIN_W-1:0] org_i,
  input  wire logic [abbt_pkg::WIN_W-1:0] len_i,
  output abbt_pkg::clip_t                 clip_o
);

  localparam int unsigned CW = abbt_pkg::CLIP_W;

  logic signed [CW-1:0] size_s;
  logic signed [CW-1:0] org_s;
  logic signed [CW-1:0] len_s;
  logic signed [CW-1:0] org1;
  logic signed [CW-1:0] len1;
  logic signed [CW-1:0] sum1;
  logic signed [CW-1:0] len2;
  logic signed [CW-1:0] stop2;
  logic                 past_edge;

  // Widen: origin is signed, size and length are not
  assign size_s = signed'({{(CW-abbt_pkg::DIM_W){1'b0}}, size_i});
  assign org_s  = signed'({{(CW-abbt_pkg::WIN_W){org_i[abbt_pkg::WIN_W-1]}}, org_i});
  assign len_s  = signed'({{(CW-abbt_pkg::WIN_W){1'b0}}, len_i});

  // Fold a negative origin into the length, flag an origin past the edge
  always_comb begin
    past_edge = 1'b0;
    org1      = org_s;
    len1      = len_s;
    if (org_s < 0) begin
      len1 = len_s + org_s;
      org1 = '0;
    end else if (org_s > size_s) begin
      past_edge = 1'b1;
    end
  end

  // Cut the far edge back to the image edge
  assign sum1 = len1 + org1;

  always_comb begin
    if (sum1 > size_s) begin
      len2  = size_s - org1;
      stop2 = size_s;
    end else begin
      len2  = len1;
      stop2 = sum1;
    end
  end

  assign clip_o.ok    = !past_edge && (len2 > 0);
  assign clip_o.start = org1[abbt_pkg::DIM_W-1:0];
  assign clip_o.stop  = stop2[abbt_pkg::DIM_W-1:0];

endmodule

`default_nettype wire

FILE: sim/alpha_bounding_box_trim_test.sv
// Self-checking bench: streams alpha frames through varied clipped windows, checks each box beat.
`timescale 1ns / 1ps

module alpha_bounding_box_trim_test;

  localparam int unsigned DIM_MAX       = 4096;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASE_PIXELS  = 400;

  // One bounding box beat as the result channel carries it
  typedef struct packed {
    logic                       found;
    logic [abbt_pkg::POS_W-1:0] left;
    logic [abbt_pkg::POS_W-1:0] top;
    logic [abbt_pkg::EXT_W-1:0] width;
    logic [abbt_pkg::EXT_W-1:0] height;
  } bbox_t;

  // Register setting plus one small frame, with an optional typed-in box
  typedef struct packed {
    logic [abbt_pkg::DIM_W-1:0]   img_w;
    logic [abbt_pkg::DIM_W-1:0]   img_h;
    logic [abbt_pkg::WIN_W-1:0]   win_x;
    logic [abbt_pkg::WIN_W-1:0]   win_y;
    logic [abbt_pkg::WIN_W-1:0]   win_w;
    logic [abbt_pkg::WIN_W-1:0]   win_h;
    logic [15:0]                  opaque_mask;
    logic [abbt_pkg::ALPHA_W-1:0] alpha;
    logic                         typed;
    bbox_t                        want;
  } frame_case_t;

  typedef enum int {FILL_CLEAR, FILL_SPARSE, FILL_HALF, FILL_NOISE} fill_e;

  localparam bbox_t NO_BOX = '0;

  // Directed frames, pixel i of the frame is opaque when opaque_mask[i] is set
  frame_case_t frame_cases [10] = '{
    // one opaque pixel fills a 1x1 window
    '{13'd1, 13'd1, 14'd0, 14'd0, 14'd1, 14'd1, 16'h0001, 8'hFF, 1'b1,
      '{1'b1, 12'd0, 12'd0, 13'd1, 13'd1}},
    // fully transparent frame
    '{13'd1, 13'd1, 14'd0, 14'd0, 14'd1, 14'd1, 16'h0001, 8'h00, 1'b1, NO_BOX},
    // two opaque pixels on different rows and columns
    '{13'd3, 13'd2, 14'd0, 14'd0, 14'd3, 14'd2, 16'h0022, 8'h01, 1'b0, NO_BOX},
    // negative origin shrinks the window
    '{13'd3, 13'd2, 14'(-1), 14'(-1), 14'd3, 14'd3, 16'h003F, 8'h80, 1'b0, NO_BOX},
    // origin past the right edge
    '{13'd2, 13'd1, 14'd3, 14'd0, 14'd1, 14'd1, 16'h0003, 8'hFF, 1'b1, NO_BOX},
    // origin right on the edge leaves zero width
    '{13'd2, 13'd1, 14'd2, 14'd0, 14'd2, 14'd1, 16'h0003, 8'hAA, 1'b1, NO_BOX},
    // zero window height
    '{13'd1, 13'd2, 14'd0, 14'd0, 14'd1, 14'd0, 16'h0003, 8'h55, 1'b1, NO_BOX},
    // zero image size taken as one, an 8192 by 8192 window clipped to it
    '{13'd0, 13'd0, 14'd0, 14'd0, 14'd8192, 14'd8192, 16'h0001, 8'h7F, 1'b1,
      '{1'b1, 12'd0, 12'd0, 13'd1, 13'd1}},
    // opaque row above a window that is transparent over its clipped height
    '{13'd2, 13'd2, 14'd0, 14'd1, 14'd2, 14'd4, 16'h0003, 8'hFF, 1'b1, NO_BOX},
    // origin of -4096 with an 8192-wide request
    '{13'd3, 13'd1, 14'(-4096), 14'd0, 14'd8192, 14'd1, 16'h0004, 8'h01, 1'b0, NO_BOX}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  abbt_pix_if pix_if ();
  abbt_cfg_if cfg_if ();
  abbt_res_if res_if ();

  alpha_bounding_box_trim #(
    .MAX_DIM(DIM_MAX)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix_if),
    .cfg_i (cfg_if),
    .res_o (res_if)
  );

  // Register mirror and frame tracking state
  logic [abbt_pkg::DIM_W-1:0] img_w_q;
  logic [abbt_pkg::DIM_W-1:0] img_h_q;
  logic [abbt_pkg::WIN_W-1:0] win_x_q;
  logic [abbt_pkg::WIN_W-1:0] win_y_q;
  logic [abbt_pkg::WIN_W-1:0] win_w_q;
  logic [abbt_pkg::WIN_W-1:0] win_h_q;
  logic [abbt_pkg::POS_W-1:0] col_pos;
  logic [abbt_pkg::POS_W-1:0] row_pos;
  logic [abbt_pkg::POS_W-1:0] left_col;
  logic [abbt_pkg::POS_W-1:0] right_col;
  logic [abbt_pkg::POS_W-1:0] top_row;
  logic [abbt_pkg::POS_W-1:0] bottom_row;
  logic                       seen_opaque;

  bbox_t       boxes_due [$];
  bit          take_typed = 1'b0;
  bbox_t       typed_box;
  frame_case_t cur_setting;
  int unsigned mismatches   = 0;
  int unsigned pixels_sent  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned src_idle_pct = 16;
  int unsigned snk_idle_pct = 73;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int dim_used(input logic [abbt_pkg::DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > DIM_MAX) return DIM_MAX;
    return int'(v);
  endfunction

  // Clip one axis of the window to the image; 0 when nothing is left
  function automatic bit clip_span(input int size, input int org_in, input int len_in,
                                   output int org, output int len);
    org = org_in;
    len = len_in;
    if (org < 0) begin
      len += org;
      org = 0;
    end else if (org > size) begin
      return 1'b0;
    end
    if (len + org > size) len = size - org;
    return len > 0;
  endfunction

  function automatic void clear_frame();
    col_pos     = '0;
    row_pos     = '0;
    left_col    = '0;
    right_col   = '0;
    top_row     = '0;
    bottom_row  = '0;
    seen_opaque = 1'b0;
  endfunction

  // Score one pixel beat; queue the box when it closes the frame
  task automatic score_pixel(input logic [abbt_pkg::ALPHA_W-1:0] a);
    int w, h, cx, cy, cw, ch, col, row;
    bit in_win;
    logic [abbt_pkg::POS_W-1:0] rc, rr;
    bbox_t box;
    w      = dim_used(img_w_q);
    h      = dim_used(img_h_q);
    in_win = clip_span(w, int'($signed(win_x_q)), int'(win_w_q), cx, cw);
    in_win = clip_span(h, int'($signed(win_y_q)), int'(win_h_q), cy, ch) && in_win;
    col    = int'(col_pos);
    row    = int'(row_pos);
    if (in_win && a != '0 && col >= cx && col < cx + cw && row >= cy && row < cy + ch) begin
      rc = abbt_pkg::POS_W'(col - cx);
      rr = abbt_pkg::POS_W'(row - cy);
      if (!seen_opaque) begin
        left_col    = rc;
        right_col   = rc;
        top_row     = rr;
        bottom_row  = rr;
        seen_opaque = 1'b1;
      end else begin
        if (rc < left_col) left_col = rc;
        if (rc > right_col) right_col = rc;
        if (rr < top_row) top_row = rr;
        if (rr > bottom_row) bottom_row = rr;
      end
    end
    // advance the raster position, close the frame on its last pixel
    if (col + 1 < w) begin
      col_pos = col_pos + abbt_pkg::POS_W'(1);
    end else begin
      col_pos = '0;
      if (row + 1 < h) begin
        row_pos = row_pos + abbt_pkg::POS_W'(1);
      end else begin
        box = NO_BOX;
        if (seen_opaque) begin
          box.found  = 1'b1;
          box.left   = left_col;
          box.top    = top_row;
          box.width  = abbt_pkg::EXT_W'(right_col) - abbt_pkg::EXT_W'(left_col)
                     + abbt_pkg::EXT_W'(1);
          box.height = abbt_pkg::EXT_W'(bottom_row) - abbt_pkg::EXT_W'(top_row)
                     + abbt_pkg::EXT_W'(1);
        end
        boxes_due.push_back(take_typed ? typed_box : box);
        clear_frame();
      end
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Check result beats, mirror register writes, score pixel beats
  always @(posedge clk_i) begin
    bbox_t want;
    if (!rst_ni) begin
      img_w_q = abbt_pkg::RST_IMAGE_WIDTH;
      img_h_q = abbt_pkg::RST_IMAGE_HEIGHT;
      win_x_q = abbt_pkg::RST_WINDOW_X;
      win_y_q = abbt_pkg::RST_WINDOW_Y;
      win_w_q = abbt_pkg::RST_WINDOW_WIDTH;
      win_h_q = abbt_pkg::RST_WINDOW_HEIGHT;
      clear_frame();
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (boxes_due.size() == 0) begin
          flag_mismatch("result beat with no frame pending, found",
                        32'(res_if.found), 32'(0));
        end else begin
          want = boxes_due.pop_front();
          if (res_if.found !== want.found)
            flag_mismatch("found", 32'(res_if.found), 32'(want.found));
          if (res_if.box_left !== want.left)
            flag_mismatch("box_left", 32'(res_if.box_left), 32'(want.left));
          if (res_if.box_top !== want.top)
            flag_mismatch("box_top", 32'(res_if.box_top), 32'(want.top));
          if (res_if.box_width !== want.width)
            flag_mismatch("box_width", 32'(res_if.box_width), 32'(want.width));
          if (res_if.box_height !== want.height)
            flag_mismatch("box_height", 32'(res_if.box_height), 32'(want.height));
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (abbt_pkg::cfg_reg_e'(cfg_if.index))
          abbt_pkg::CFG_IMAGE_WIDTH:   img_w_q = cfg_if.data[abbt_pkg::DIM_W-1:0];
          abbt_pkg::CFG_IMAGE_HEIGHT:  img_h_q = cfg_if.data[abbt_pkg::DIM_W-1:0];
          abbt_pkg::CFG_WINDOW_X:      win_x_q = cfg_if.data;
          abbt_pkg::CFG_WINDOW_Y:      win_y_q = cfg_if.data;
          abbt_pkg::CFG_WINDOW_WIDTH:  win_w_q = cfg_if.data;
          abbt_pkg::CFG_WINDOW_HEIGHT: win_h_q = cfg_if.data;
          default: ;
        endcase
      end
      if (pix_if.valid && pix_if.ready) score_pixel(pix_if.alpha);
    end
  end

  // Stall the result channel at the current rate
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= rst_ni && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // End the run when no beat moves for too long
  always @(posedge clk_i) begin
    if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_pixel(input logic [abbt_pkg::ALPHA_W-1:0] a);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.alpha <= a;
    do @(posedge clk_i); while (!pix_if.ready);
    pixels_sent++;
  endtask

  task automatic write_reg(input abbt_pkg::cfg_reg_e idx,
                           input logic [abbt_pkg::WIN_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  // Hold the pixel channel until every queued box has come out
  task automatic drain();
    pix_if.valid <= 1'b0;
    do @(negedge clk_i); while (boxes_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_setting(input frame_case_t s);
    drain();
    cur_setting = s;
    write_reg(abbt_pkg::CFG_IMAGE_WIDTH, abbt_pkg::WIN_W'(s.img_w));
    write_reg(abbt_pkg::CFG_IMAGE_HEIGHT, abbt_pkg::WIN_W'(s.img_h));
    write_reg(abbt_pkg::CFG_WINDOW_X, s.win_x);
    write_reg(abbt_pkg::CFG_WINDOW_Y, s.win_y);
    write_reg(abbt_pkg::CFG_WINDOW_WIDTH, s.win_w);
    write_reg(abbt_pkg::CFG_WINDOW_HEIGHT, s.win_h);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [abbt_pkg::ALPHA_W-1:0] pick_alpha(input fill_e fill);
    case (fill)
      FILL_CLEAR:  return '0;
      FILL_SPARSE: return ($urandom_range(9) == 0) ?
                          abbt_pkg::ALPHA_W'($urandom_range(1, 255)) : '0;
      FILL_HALF:   return ($urandom_range(1) == 0) ?
                          abbt_pkg::ALPHA_W'($urandom_range(1, 255)) : '0;
      default:     return abbt_pkg::ALPHA_W'($urandom());
    endcase
  endfunction

  task automatic send_frame(input fill_e fill);
    int n;
    n = dim_used(cur_setting.img_w) * dim_used(cur_setting.img_h);
    repeat (n) send_pixel(pick_alpha(fill));
  endtask

  // Mostly small images, now and then zero or a little larger
  function automatic logic [abbt_pkg::DIM_W-1:0] pick_dim(input int unsigned top);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return abbt_pkg::DIM_W'($urandom_range(top + 1, 2 * top));
    return abbt_pkg::DIM_W'($urandom_range(1, top));
  endfunction

  function automatic logic [abbt_pkg::WIN_W-1:0] pick_origin(input int size);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return abbt_pkg::WIN_W'(int'($urandom_range(size + 4)) - 2);
    if (r < 80) return abbt_pkg::WIN_W'(-4096);
    if (r < 90) return abbt_pkg::WIN_W'(4096);
    return abbt_pkg::WIN_W'($urandom());
  endfunction

  function automatic logic [abbt_pkg::WIN_W-1:0] pick_extent(input int size);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return abbt_pkg::WIN_W'($urandom_range(size + 3));
    if (r < 80) return '0;
    if (r < 90) return abbt_pkg::WIN_W'(8192);
    return abbt_pkg::WIN_W'($urandom());
  endfunction

  function automatic frame_case_t random_setting();
    frame_case_t s;
    s       = '0;
    s.img_w = pick_dim(8);
    s.img_h = pick_dim(6);
    s.win_x = pick_origin(dim_used(s.img_w));
    s.win_y = pick_origin(dim_used(s.img_h));
    s.win_w = pick_extent(dim_used(s.img_w));
    s.win_h = pick_extent(dim_used(s.img_h));
    return s;
  endfunction

  // Run back-to-back frames under random settings until the phase is full
  task automatic run_random(input int unsigned src_pct, input int unsigned snk_pct);
    int unsigned start;
    int unsigned frames;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    start        = pixels_sent;
    while (pixels_sent - start < PHASE_PIXELS) begin
      apply_setting(random_setting());
      frames = $urandom_range(1, 3);
      repeat (frames) send_frame(fill_e'($urandom_range(3)));
    end
  endtask

  initial begin
    int n;
    rst_ni       <= 1'b0;
    pix_if.valid <= 1'b0;
    pix_if.alpha <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed frames
    foreach (frame_cases[i]) begin
      apply_setting(frame_cases[i]);
      take_typed = frame_cases[i].typed;
      typed_box  = frame_cases[i].want;
      n = dim_used(frame_cases[i].img_w) * dim_used(frame_cases[i].img_h);
      for (int p = 0; p < n; p++)
        send_pixel(frame_cases[i].opaque_mask[p] ? frame_cases[i].alpha : '0);
    end
    drain();
    take_typed = 1'b0;

    run_random(16, 73);
    run_random(73, 16);

    // long single row and single column with clipped windows, no idling
    src_idle_pct = 0;
    snk_idle_pct = 0;
    apply_setting('{13'd256, 13'd1, 14'd100, 14'd0, 14'd8192, 14'd1,
                    16'h0000, 8'h00, 1'b0, NO_BOX});
    send_frame(FILL_SPARSE);
    apply_setting('{13'd0, 13'd256, 14'd0, 14'd200, 14'd1, 14'd8192,
                    16'h0000, 8'h00, 1'b0, NO_BOX});
    send_frame(FILL_SPARSE);
    run_random(0, 0);

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
